### src/lex3_pkg.sv
// ----------------------------------------------------------------------------
// lex3_pkg
// Shared types, sizes and the neighborhood test for the 3x3 extrema detector.
// ----------------------------------------------------------------------------
`default_nettype none

package lex3_pkg;

    localparam int MAX_WIDTH      = 64;
    localparam int MAX_HEIGHT     = 4096;
    localparam int PIXEL_BITS     = 8;
    localparam int COL_BITS       = 6;
    localparam int ROW_BITS       = 12;
    localparam int WIDTH_BITS     = 7;
    localparam int HEIGHT_BITS    = 13;
    localparam int CFG_INDEX_BITS = 8;
    localparam int N_CAND         = 4;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS     = $clog2(Q_DEPTH + 1);

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_GRID_WIDTH  = cfg_index_t'(0);
    localparam cfg_index_t CFG_GRID_HEIGHT = cfg_index_t'(1);

    // result candidates of one step, in delivery order
    typedef logic [1:0] cand_t;
    localparam cand_t CAND_UL = 2'd0;  // (r-1, c-1)
    localparam cand_t CAND_UR = 2'd1;  // (r-1, c)
    localparam cand_t CAND_LL = 2'd2;  // (r, c-1)
    localparam cand_t CAND_LR = 2'd3;  // (r, c)

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef pix_t [2:0][2:0] window_t;

    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } col_pair_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        pix_t [N_CAND-1:0]   val;
        logic [N_CAND-1:0]   is_max;
        logic [N_CAND-1:0]   is_min;
        logic [N_CAND-1:0]   en;
    } step_rec_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // bit 1: local max, bit 0: local min; row_ok/col_ok mark window rows
    // and columns that lie inside the grid
    function automatic logic [1:0] judge(window_t win, int ci, int cj,
                                         logic [2:0] row_ok, logic [2:0] col_ok);
        logic mx;
        logic mn;
        mx = 1'b1;
        mn = 1'b1;
        for (int wi = 0; wi < 3; wi++) begin
            for (int wj = 0; wj < 3; wj++) begin
                if ((wi >= ci - 1) && (wi <= ci + 1) && (wj >= cj - 1) &&
                    (wj <= cj + 1) && !((wi == ci) && (wj == cj)) &&
                    row_ok[wi] && col_ok[wj])
                begin
                    if (win[wi][wj] >= win[ci][cj]) mx = 1'b0;
                    if (win[wi][wj] <= win[ci][cj]) mn = 1'b0;
                end
            end
        end
        return {mx, mn};
    endfunction

endpackage

`default_nettype wire

### src/lex3_front.sv
// ----------------------------------------------------------------------------
// lex3_front
// Accepts pixels, keeps row stores and the 3x3 window, and classifies each
// step into up to four result candidates pushed to the queue as one record.
// ----------------------------------------------------------------------------
`default_nettype none

module lex3_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire lex3_pkg::cfg_index_t                  cfg_index,
    input  wire logic [lex3_pkg::HEIGHT_BITS-1:0]      cfg_data,
    input  wire logic                                  pix_valid,
    output logic                                       pix_stall,
    input  wire logic [lex3_pkg::PIXEL_BITS-1:0]       pixel_value,
    input  wire lex3_pkg::q_status_t                   q_stat,
    output logic                                       push,
    output lex3_pkg::step_rec_t                        push_rec
);
    import lex3_pkg::*;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [COL_BITS-1:0]    col_last;
    logic [ROW_BITS-1:0]    row_last;
    logic                   row_end, last_row;
    logic                   accept;

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_fire;
    pix_t                   s1_pix_reg;
    logic [ROW_BITS-1:0]    s1_row_reg;
    logic [COL_BITS-1:0]    s1_col_reg;
    logic                   s1_row_end_reg, s1_last_row_reg;
    logic                   bypass_reg, bypass_next;
    col_pair_t              byp_data_reg;
    col_pair_t              rd_data_reg;
    col_pair_t              col_pair, wr_pair;

    col_pair_t              store_mem [MAX_WIDTH];

    window_t                window_reg, window_next;
    logic [2:0]             row_ok, col_ok;
    logic [N_CAND-1:0]      en;
    logic [1:0]             j_ul, j_ur, j_ll, j_lr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_BITS'(20);
            height_reg <= HEIGHT_BITS'(20);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective last column and row after clamping the registers
    always_comb
    begin
        if (width_reg == '0)
            col_last = '0;
        else if (width_reg > WIDTH_BITS'(MAX_WIDTH))
            col_last = COL_BITS'(MAX_WIDTH - 1);
        else
            col_last = COL_BITS'(width_reg - 1'b1);

        if (height_reg == '0)
            row_last = '0;
        else if (height_reg > HEIGHT_BITS'(MAX_HEIGHT))
            row_last = ROW_BITS'(MAX_HEIGHT - 1);
        else
            row_last = ROW_BITS'(height_reg - 1'b1);
    end

    assign row_end  = col_reg >= col_last;
    assign last_row = row_reg >= row_last;

    assign en[CAND_UL] = (s1_row_reg != '0) && (s1_col_reg != '0);
    assign en[CAND_UR] = (s1_row_reg != '0) && s1_row_end_reg;
    assign en[CAND_LL] = s1_last_row_reg && (s1_col_reg != '0);
    assign en[CAND_LR] = s1_last_row_reg && s1_row_end_reg;

    assign s1_fire   = s1_valid_reg && ((en == '0) || !q_stat.full);
    assign pix_stall = s1_valid_reg && !s1_fire;
    assign accept    = pix_valid && !pix_stall;
    assign push      = s1_fire && (en != '0);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        // a store read at the column being written this cycle sees old data
        bypass_next = accept ? (s1_fire && (s1_col_reg == col_reg)) : bypass_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            bypass_reg   <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            bypass_reg   <= bypass_next;
            if (s1_fire)
                window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pixel_value;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_row_end_reg  <= row_end;
            s1_last_row_reg <= last_row;
            byp_data_reg    <= wr_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= store_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            store_mem[s1_col_reg] <= wr_pair;
    end

    assign col_pair       = bypass_reg ? byp_data_reg : rd_data_reg;
    assign wr_pair.upper  = col_pair.middle;
    assign wr_pair.middle = s1_pix_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            window_next[i][0] = window_reg[i][1];
            window_next[i][1] = window_reg[i][2];
        end
        window_next[0][2] = col_pair.upper;
        window_next[1][2] = col_pair.middle;
        window_next[2][2] = s1_pix_reg;
    end

    assign row_ok = {1'b1, s1_row_reg != '0, s1_row_reg > ROW_BITS'(1)};
    assign col_ok = {1'b1, s1_col_reg != '0, s1_col_reg > COL_BITS'(1)};

    assign j_ul = judge(window_next, 1, 1, row_ok, col_ok);
    assign j_ur = judge(window_next, 1, 2, row_ok, col_ok);
    assign j_ll = judge(window_next, 2, 1, row_ok, col_ok);
    assign j_lr = judge(window_next, 2, 2, row_ok, col_ok);

    always_comb
    begin
        push_rec.row          = s1_row_reg;
        push_rec.col          = s1_col_reg;
        push_rec.en           = en;
        push_rec.val[CAND_UL] = window_next[1][1];
        push_rec.val[CAND_UR] = window_next[1][2];
        push_rec.val[CAND_LL] = window_next[2][1];
        push_rec.val[CAND_LR] = window_next[2][2];
        push_rec.is_max       = {j_lr[1], j_ll[1], j_ur[1], j_ul[1]};
        push_rec.is_min       = {j_lr[0], j_ll[0], j_ur[0], j_ul[0]};
    end

endmodule

`default_nettype wire

### src/lex3_queue.sv
// ----------------------------------------------------------------------------
// lex3_queue
// Short queue of step records between the classifier and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module lex3_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lex3_pkg::step_rec_t  push_rec,
    input  wire logic                 pop,
    output lex3_pkg::q_status_t       q_stat,
    output lex3_pkg::step_rec_t       head
);
    import lex3_pkg::*;

    step_rec_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign q_stat.not_empty = count_reg != '0;
    assign q_stat.full      = count_reg == Q_CNT_BITS'(Q_DEPTH);

endmodule

`default_nettype wire

### src/lex3_back.sv
// ----------------------------------------------------------------------------
// lex3_back
// Walks the candidates of the head record and delivers one result per cycle
// through the output register while res_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module lex3_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lex3_pkg::q_status_t               q_stat,
    input  wire lex3_pkg::step_rec_t               head,
    output logic                                   pop,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [lex3_pkg::ROW_BITS-1:0]          row_index,
    output logic [lex3_pkg::COL_BITS-1:0]          col_index,
    output logic [lex3_pkg::PIXEL_BITS-1:0]        center_value,
    output logic                                   is_local_max,
    output logic                                   is_local_min,
    output logic                                   run_last,
    output logic                                   frame_last
);
    import lex3_pkg::*;

    logic [N_CAND-1:0]   done_reg, done_next;
    logic [N_CAND-1:0]   rem;
    logic [N_CAND-1:0]   cand_bit;
    cand_t               pick;
    logic                last;
    logic                load;
    logic                res_valid_reg, res_valid_next;

    logic [ROW_BITS-1:0] row_index_reg;
    logic [COL_BITS-1:0] col_index_reg;
    pix_t                center_value_reg;
    logic                is_max_reg, is_min_reg, run_last_reg, frame_last_reg;

    assign rem = head.en & ~done_reg;

    always_comb
    begin
        priority if (rem[CAND_UL]) pick = CAND_UL;
        else if (rem[CAND_UR])     pick = CAND_UR;
        else if (rem[CAND_LL])     pick = CAND_LL;
        else                       pick = CAND_LR;
    end

    assign cand_bit = N_CAND'(1) << pick;
    assign last     = (rem & ~cand_bit) == '0;
    assign load     = q_stat.not_empty && (!res_valid_reg || !res_stall);
    assign pop      = load && last;

    always_comb
    begin
        done_next = done_reg;
        if (load)
            done_next = last ? '0 : (done_reg | cand_bit);
        res_valid_next = res_valid_reg;
        if (load)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_index_reg    <= ((pick == CAND_UL) || (pick == CAND_UR)) ?
                                head.row - 1'b1 : head.row;
            col_index_reg    <= ((pick == CAND_UL) || (pick == CAND_LL)) ?
                                head.col - 1'b1 : head.col;
            center_value_reg <= head.val[pick];
            is_max_reg       <= head.is_max[pick];
            is_min_reg       <= head.is_min[pick];
            run_last_reg     <= last;
            frame_last_reg   <= pick == CAND_LR;
        end
    end

    assign res_valid    = res_valid_reg;
    assign row_index    = row_index_reg;
    assign col_index    = col_index_reg;
    assign center_value = center_value_reg;
    assign is_local_max = is_max_reg;
    assign is_local_min = is_min_reg;
    assign run_last     = run_last_reg;
    assign frame_last   = frame_last_reg;

endmodule

`default_nettype wire

### src/local_extrema_3x3_detector.sv
// ----------------------------------------------------------------------------
// local_extrema_3x3_detector
// Streams a raster-ordered grid and flags 3x3 local maxima and minima.
// ----------------------------------------------------------------------------
// Pixels enter on pix_valid/pix_stall, one grid value per item, row by row.
// Every grid position comes out once on res_valid/res_stall with its row,
// column, value and max/min flags, in raster order but the last two rows
// interleave; run_last ends a pixel's results, frame_last the final position.
// grid_width (index 0) and grid_height (index 1) are written on the cfg
// channel, which is always ready; write them only while the block is idle.
// Results of a pixel lag by about one row and one column; the last pixel of
// the grid drains the remaining positions, up to four results for it.
// Pipeline: accept and row-store read, classify and push into a four-record
// queue, then one result per cycle into the output register while res_stall
// is low. With nothing waiting, a pixel goes through the stage-one registers
// and a queue entry to the output register. Pixels are taken one per cycle
// while pix_stall is low; a pixel with more than one result holds the back end
// while they go out, and the queue absorbs row-end and frame-end bursts.
// When the receiver stalls, the output holds, the queue fills, and then
// pix_stall rises. Reset clears counters, window and queue; no clearing
// pass is needed, so the block accepts pixels right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module local_extrema_3x3_detector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire lex3_pkg::cfg_index_t              cfg_index,
    input  wire logic [lex3_pkg::HEIGHT_BITS-1:0]  cfg_data,
    input  wire logic                              pix_valid,
    output logic                                   pix_stall,
    input  wire logic [lex3_pkg::PIXEL_BITS-1:0]   pixel_value,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [lex3_pkg::ROW_BITS-1:0]          row_index,
    output logic [lex3_pkg::COL_BITS-1:0]          col_index,
    output logic [lex3_pkg::PIXEL_BITS-1:0]        center_value,
    output logic                                   is_local_max,
    output logic                                   is_local_min,
    output logic                                   run_last,
    output logic                                   frame_last
);
    import lex3_pkg::*;

    q_status_t  q_stat;
    step_rec_t  push_rec;
    step_rec_t  head;
    logic       q_push;
    logic       q_pop;

    lex3_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel_value (pixel_value),
        .q_stat      (q_stat),
        .push        (q_push),
        .push_rec    (push_rec)
    );

    lex3_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .q_stat   (q_stat),
        .head     (head)
    );

    lex3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (q_pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .row_index    (row_index),
        .col_index    (col_index),
        .center_value (center_value),
        .is_local_max (is_local_max),
        .is_local_min (is_local_min),
        .run_last     (run_last),
        .frame_last   (frame_last)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("step record pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("step record popped from an empty queue");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_last |-> run_last)
        else $error("final grid position not closing its pixel's results");

    // only an isolated position, a 1x1 grid, can be both
    a_both_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_local_max && is_local_min |->
            (row_index == '0) && (col_index == '0))
        else $error("max and min flags both set away from the origin");

endmodule

`default_nettype wire
